// ===== rtl/note_name_parser_to_midi_macros.svh =====
// Assertion macros shared by the checker of the note name parser.
`ifndef NOTE_NAME_PARSER_TO_MIDI_MACROS_SVH
`define NOTE_NAME_PARSER_TO_MIDI_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define NNM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define NNM_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nnm_pkg.sv =====
// Package with the types, character codes and tables of the note name parser.
package nnm_pkg;

    typedef enum logic [3:0] {
        PH_LETTER,
        PH_AFTER,
        PH_I,
        PH_IS,
        PH_ISI,
        PH_E,
        PH_ES,
        PH_ESE,
        PH_MARKS,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [2:0]        letter;
        logic signed [2:0] acc;
        logic signed [5:0] oct;
    } t_token;

    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2c;

    localparam logic signed [5:0] OCT_MAX   = 6'sd31;
    localparam logic signed [5:0] OCT_MIN   = 6'sb100000;
    localparam logic signed [5:0] OCT_RESET = 6'sd3;

    function automatic logic [2:0] letter_of_char(input logic [7:0] c);
        logic [2:0] s;
        case (c)
            8'h61:   s = 3'd5;
            8'h62:   s = 3'd6;
            8'h63:   s = 3'd0;
            8'h64:   s = 3'd1;
            8'h65:   s = 3'd2;
            8'h66:   s = 3'd3;
            8'h67:   s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] semitone_of_step(input logic [2:0] step);
        logic [3:0] s;
        case (step)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd2;
            3'd2:    s = 4'd4;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd9;
            3'd6:    s = 4'd11;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/nnm_if.sv =====
// Channel interfaces for the note name bytes and the pitch results.
interface nnm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_token;

    modport source (output valid, output char_code, output end_of_token, input ready);
    modport sink (input valid, input char_code, input end_of_token, output ready);
endinterface

interface nnm_out_if;
    logic              valid;
    logic              ready;
    logic              valid_res;
    logic [2:0]        step_index;
    logic signed [2:0] accidental;
    logic signed [5:0] octave;
    logic signed [9:0] midi_number;
    logic signed [8:0] staff_step;

    modport source (output valid, output valid_res, output step_index, output accidental,
                    output octave, output midi_number, output staff_step, input ready);
    modport sink (input valid, input valid_res, input step_index, input accidental,
                  input octave, input midi_number, input staff_step, output ready);
endinterface

// ===== rtl/nnm_parser.sv =====
// Input register and per-byte parser state machine of the note name parser.
module nnm_parser
    import nnm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    nnm_in_if.sink i_in,
    input  logic   i_take,
    output t_token o_tok
);

    typedef struct packed {
        t_phase            phase;
        logic signed [5:0] oct;
    } t_mark;

    function automatic t_mark take_mark(input logic [7:0] c, input logic signed [5:0] oct);
        t_mark m;
        m.oct = oct;
        if (c == CH_APOS) begin
            if (oct != OCT_MAX) m.oct = oct + 6'sd1;
            m.phase = PH_MARKS;
        end else if (c == CH_COMMA) begin
            if (oct != OCT_MIN) m.oct = oct - 6'sd1;
            m.phase = PH_MARKS;
        end else begin
            m.phase = PH_ERROR;
        end
        return m;
    endfunction

    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_in_eot;
    t_phase            r_phase;
    logic [2:0]        r_letter;
    logic signed [2:0] r_acc;
    logic signed [5:0] r_oct;

    t_phase            n_phase;
    logic [2:0]        n_letter;
    logic signed [2:0] n_acc;
    logic signed [5:0] n_oct;
    t_mark             w_mark;
    logic              w_fire;

    assign w_fire     = r_in_valid && (!r_in_eot || i_take);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_in_char <= i_in.char_code;
            r_in_eot  <= i_in.end_of_token;
        end
    end

    always_comb begin
        w_mark   = take_mark(r_in_char, r_oct);
        n_phase  = r_phase;
        n_letter = r_letter;
        n_acc    = r_acc;
        n_oct    = r_oct;
        case (r_phase)
            PH_LETTER: begin
                if (r_in_char >= CH_A && r_in_char <= CH_G) begin
                    n_letter = letter_of_char(r_in_char);
                    n_phase  = PH_AFTER;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_AFTER: begin
                if (r_in_char == CH_I) begin
                    n_phase = PH_I;
                end else if (r_in_char == CH_E) begin
                    n_phase = PH_E;
                end else begin
                    n_phase = w_mark.phase;
                    n_oct   = w_mark.oct;
                end
            end
            PH_I: begin
                if (r_in_char == CH_S) begin
                    n_acc   = 3'sd1;
                    n_phase = PH_IS;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_IS: begin
                if (r_in_char == CH_I) begin
                    n_phase = PH_ISI;
                end else begin
                    n_phase = w_mark.phase;
                    n_oct   = w_mark.oct;
                end
            end
            PH_ISI: begin
                if (r_in_char == CH_S) begin
                    n_acc   = 3'sd2;
                    n_phase = PH_MARKS;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_E: begin
                if (r_in_char == CH_S) begin
                    n_acc   = -3'sd1;
                    n_phase = PH_ES;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_ES: begin
                if (r_in_char == CH_E) begin
                    n_phase = PH_ESE;
                end else begin
                    n_phase = w_mark.phase;
                    n_oct   = w_mark.oct;
                end
            end
            PH_ESE: begin
                if (r_in_char == CH_S) begin
                    n_acc   = -3'sd2;
                    n_phase = PH_MARKS;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_MARKS: begin
                n_phase = w_mark.phase;
                n_oct   = w_mark.oct;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_comb begin
        o_tok.valid  = r_in_valid && r_in_eot;
        o_tok.ok     = n_phase inside {PH_AFTER, PH_IS, PH_ES, PH_MARKS};
        o_tok.letter = n_letter;
        o_tok.acc    = n_acc;
        o_tok.oct    = n_oct;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LETTER;
            r_letter <= 3'd0;
            r_acc    <= 3'sd0;
            r_oct    <= OCT_RESET;
        end else if (w_fire) begin
            if (r_in_eot) begin
                r_phase  <= PH_LETTER;
                r_letter <= 3'd0;
                r_acc    <= 3'sd0;
                r_oct    <= OCT_RESET;
            end else begin
                r_phase  <= n_phase;
                r_letter <= n_letter;
                r_acc    <= n_acc;
                r_oct    <= n_oct;
            end
        end
    end

endmodule

// ===== rtl/nnm_result.sv =====
// Result register that turns a finished note name into MIDI and staff numbers.
module nnm_result
    import nnm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_token    i_tok,
    output logic      o_take,
    nnm_out_if.source o_out
);

    logic              r_valid;
    logic              r_valid_res;
    logic [2:0]        r_step;
    logic signed [2:0] r_acc;
    logic signed [5:0] r_oct;
    logic signed [9:0] r_midi;
    logic signed [8:0] r_staff;

    logic signed [9:0] w_oct10;
    logic signed [9:0] w_semi10;
    logic signed [9:0] w_acc10;
    logic signed [9:0] w_midi;
    logic signed [8:0] w_oct9;
    logic signed [8:0] w_step9;
    logic signed [8:0] w_staff;

    assign o_take = !r_valid || o_out.ready;

    always_comb begin
        w_oct10  = {{4{i_tok.oct[5]}}, i_tok.oct};
        w_semi10 = {6'b0, semitone_of_step(i_tok.letter)};
        w_acc10  = {{7{i_tok.acc[2]}}, i_tok.acc};
        w_midi   = (w_oct10 + 10'sd1) * 10'sd12 + w_semi10 + w_acc10;
        w_oct9   = {{3{i_tok.oct[5]}}, i_tok.oct};
        w_step9  = {6'b0, i_tok.letter};
        w_staff  = w_oct9 * 9'sd7 + w_step9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_tok.valid;
        end
        if (o_take && i_tok.valid) begin
            r_valid_res <= i_tok.ok;
            if (i_tok.ok) begin
                r_step  <= i_tok.letter;
                r_acc   <= i_tok.acc;
                r_oct   <= i_tok.oct;
                r_midi  <= w_midi;
                r_staff <= w_staff;
            end else begin
                r_step  <= 3'd0;
                r_acc   <= 3'sd0;
                r_oct   <= 6'sd0;
                r_midi  <= 10'sd0;
                r_staff <= 9'sd0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.valid_res   = r_valid_res;
    assign o_out.step_index  = r_step;
    assign o_out.accidental  = r_acc;
    assign o_out.octave      = r_oct;
    assign o_out.midi_number = r_midi;
    assign o_out.staff_step  = r_staff;

endmodule

// ===== rtl/note_name_parser_to_midi.sv =====
// Top level of the Dutch note name to MIDI parser.
// The input channel carries one byte of a note name per beat, with
// end_of_token set on the last byte of the name. The output channel carries
// one result beat per name: valid_res, the step, the accidental, the octave,
// the MIDI number and the diatonic staff step. Bytes other than the last
// produce no output beat.
// A byte is registered at the input, then the parser state machine and the
// pitch arithmetic run in one pass into the output register.
// One byte is accepted every cycle while no last byte waits for the result
// register; the parser state is updated once per byte.
// When the receiver stalls, the result register holds its beat; bytes that do
// not end a name keep flowing, and a last byte waits in the input register
// until the result register is free.
// Synchronous active-low reset empties both registers and returns the parser
// to expect a note letter at octave three.
module note_name_parser_to_midi
    import nnm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    nnm_in_if.sink    i_in,
    nnm_out_if.source o_out
);

    t_token w_tok;
    logic   w_take;

    nnm_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_tok   (w_tok)
    );

    nnm_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/nnm_checker.sv =====
// Port-level assertion checker for the note name parser, bound to the top level.
`include "note_name_parser_to_midi_macros.svh"

module nnm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_valid_res,
    input logic [2:0]        i_step_index,
    input logic signed [2:0] i_accidental,
    input logic signed [5:0] i_octave,
    input logic signed [9:0] i_midi_number,
    input logic signed [8:0] i_staff_step
);

    logic signed [8:0] w_oct9;
    logic signed [8:0] w_staff;

    assign w_oct9  = {{3{i_octave[5]}}, i_octave};
    assign w_staff = w_oct9 * 9'sd7 + $signed({6'b0, i_step_index});

    `NNM_ASSERT_ALL(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `NNM_ASSERT_RST(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped while stalled")
    `NNM_ASSERT_RST(a_invalid_zero, i_clk, i_rst_n, i_out_valid && !i_valid_res |-> i_step_index == 3'd0 && i_accidental == 3'sd0 && i_octave == 6'sd0 && i_midi_number == 10'sd0 && i_staff_step == 9'sd0, "invalid result has nonzero fields")
    `NNM_ASSERT_RST(a_staff_match, i_clk, i_rst_n, i_out_valid && i_valid_res |-> i_staff_step == w_staff, "staff step disagrees with octave and step")
    `NNM_ASSERT_RST(a_fields_range, i_clk, i_rst_n, i_out_valid && i_valid_res |-> i_step_index != 3'd7 && i_accidental != 3'sb011 && i_accidental != 3'sb100, "step or accidental out of range")

endmodule

bind note_name_parser_to_midi nnm_checker u_nnm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_valid_res   (o_out.valid_res),
    .i_step_index  (o_out.step_index),
    .i_accidental  (o_out.accidental),
    .i_octave      (o_out.octave),
    .i_midi_number (o_out.midi_number),
    .i_staff_step  (o_out.staff_step)
);
